>>> hw/rtl/dcu_pkg.sv
// Shared types, constants and helper functions of the channel event unpacker.
`timescale 1ns / 1ps
`default_nettype none
package dcu_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned OUT_DATA_W = 176;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ESUM     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QDC      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXCLK    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRACE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BAD_HLEN = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MISMATCH = 3'd6;

  // Optional section bits
  localparam int unsigned OPT_ESUM_BIT  = 0;
  localparam int unsigned OPT_QDC_BIT   = 1;
  localparam int unsigned OPT_EXCLK_BIT = 2;

  localparam logic [3:0] ESUM_WORDS = 4'd4;
  localparam logic [3:0] QDC_WORDS  = 4'd8;

  // Word position inside an event; IDLE also means words are being dropped
  typedef enum logic [3:0] {
    POS_IDLE,
    POS_MODULE,
    POS_IDENT,
    POS_TSLOW,
    POS_TSHIGH,
    POS_FOURTH,
    POS_ESUM,
    POS_QDC,
    POS_EXLO,
    POS_EXHI,
    POS_TRACE
  } pos_t;

  // One result item as it leaves the block
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [47:0]       value;
    logic [14:0]       trace_len;
    logic [15:0]       energy;
    logic [63:0]       fine_time;
    logic [2:0]        flags;
    logic [12:0]       event_len;
    logic [4:0]        header_len;
    logic [3:0]        crate;
    logic [3:0]        slot;
    logic [3:0]        channel;
  } dcu_result_t;

  // Front to queue push
  typedef struct packed {
    logic        valid;
    dcu_result_t res;
  } dcu_push_t;

  // Outcome of choosing the next section
  typedef struct packed {
    pos_t       pos;
    logic [2:0] opt;
    logic [3:0] cnt;
    logic       last;
  } dcu_adv_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] opt;
  } dcu_secmap_t;

  // Optional sections selected by the header length
  function automatic dcu_secmap_t section_map(input logic [4:0] hl);
    dcu_secmap_t m;
    m.ok  = 1'b1;
    m.opt = 3'b000;
    unique case (hl)
      5'd4:  m.opt = 3'b000;
      5'd6:  m.opt = 3'b100;
      5'd8:  m.opt = 3'b001;
      5'd10: m.opt = 3'b101;
      5'd12: m.opt = 3'b010;
      5'd14: m.opt = 3'b110;
      5'd16: m.opt = 3'b011;
      default: m.ok = 1'b0;
    endcase
    return m;
  endfunction

  // Pick the next section of the event, or close it
  function automatic dcu_adv_t advance(input logic [2:0] opt, input logic [12:0] left,
                                       input logic [3:0] cnt);
    dcu_adv_t a;
    a.pos  = POS_IDLE;
    a.opt  = opt;
    a.cnt  = cnt;
    a.last = 1'b0;
    if (opt[OPT_ESUM_BIT]) begin
      a.opt[OPT_ESUM_BIT] = 1'b0;
      a.cnt = ESUM_WORDS;
      a.pos = POS_ESUM;
    end else if (opt[OPT_QDC_BIT]) begin
      a.opt[OPT_QDC_BIT] = 1'b0;
      a.cnt = QDC_WORDS;
      a.pos = POS_QDC;
    end else if (opt[OPT_EXCLK_BIT]) begin
      a.opt[OPT_EXCLK_BIT] = 1'b0;
      a.pos = POS_EXLO;
    end else if (left != 13'd0) begin
      a.pos = POS_TRACE;
    end else begin
      a.pos  = POS_IDLE;
      a.last = 1'b1;
    end
    return a;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dcu_front.sv
// Word parser: tracks the position in the event and builds result records.
`timescale 1ns / 1ps
`default_nettype none
module dcu_front
  import dcu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              start_req,
  output dcu_push_t              push
);

  pos_t        pos_r, pos_nxt;
  logic [2:0]  opt_r, opt_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [12:0] left_r, left_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [31:0] tslow_r, tslow_nxt;
  logic [63:0] fine_r, fine_nxt;
  logic [31:0] exlo_r, exlo_nxt;
  logic [15:0] energy_r, energy_nxt;
  logic [14:0] tlen_r, tlen_nxt;

  logic [4:0]  hl;
  logic [12:0] el;
  logic [14:0] tl;
  logic [13:0] tl_half;
  dcu_secmap_t smap;
  logic        mismatch;
  logic [12:0] left_hdr;
  logic [3:0]  cnt_dec;
  logic [12:0] left_dec;
  dcu_adv_t    adv;
  logic [49:0] ts_diff;
  logic [63:0] fine_calc;

  // Decode the fourth word against the stored identity word
  assign hl       = ident_r[16:12];
  assign el       = ident_r[29:17];
  assign tl       = word[30:16];
  assign tl_half  = tl[14:1];
  assign smap     = section_map(hl);
  assign mismatch = ({8'd0, hl} != {2'd0, el})
                 && ({2'd0, el} != ({10'd0, hl} + {1'b0, tl_half}));
  assign left_hdr = ({8'd0, hl} != el) ? tl_half[12:0] : 13'd0;
  assign cnt_dec  = cnt_r - 4'd1;
  assign left_dec = left_r - 13'd1;

  // Fine time: (2*ts48 - src) scaled by 2^14, CFD fraction in the low bits
  assign ts_diff   = {1'b0, word[15:0], tslow_r, 1'b0} - {49'd0, word[30]};
  assign fine_calc = {ts_diff, word[29:16]};

  // Next section after the current word
  always_comb begin
    unique case (pos_r)
      POS_FOURTH: adv = advance(smap.opt, left_hdr, cnt_r);
      POS_TRACE:  adv = advance(opt_r, left_dec, cnt_r);
      default:    adv = advance(opt_r, left_r, cnt_dec);
    endcase
  end

  // Next state
  always_comb begin
    pos_nxt    = pos_r;
    opt_nxt    = opt_r;
    cnt_nxt    = cnt_r;
    left_nxt   = left_r;
    ident_nxt  = ident_r;
    tslow_nxt  = tslow_r;
    fine_nxt   = fine_r;
    exlo_nxt   = exlo_r;
    energy_nxt = energy_r;
    tlen_nxt   = tlen_r;
    if (acc) begin
      if (start_req) begin
        pos_nxt  = POS_MODULE;
        opt_nxt  = 3'b000;
        cnt_nxt  = 4'd0;
        left_nxt = 13'd0;
      end else begin
        unique case (pos_r)
          POS_IDLE:   pos_nxt = POS_IDLE;
          POS_MODULE: pos_nxt = POS_IDENT;
          POS_IDENT: begin
            ident_nxt = word;
            pos_nxt   = POS_TSLOW;
          end
          POS_TSLOW: begin
            tslow_nxt = word;
            pos_nxt   = POS_TSHIGH;
          end
          POS_TSHIGH: begin
            fine_nxt = fine_calc;
            pos_nxt  = POS_FOURTH;
          end
          POS_FOURTH: begin
            energy_nxt = word[15:0];
            tlen_nxt   = tl;
            if (!smap.ok || mismatch) begin
              pos_nxt = POS_IDLE;
            end else begin
              pos_nxt  = adv.pos;
              opt_nxt  = adv.opt;
              cnt_nxt  = adv.cnt;
              left_nxt = left_hdr;
            end
          end
          POS_ESUM, POS_QDC: begin
            if (cnt_dec != 4'd0) begin
              cnt_nxt = cnt_dec;
            end else begin
              pos_nxt = adv.pos;
              opt_nxt = adv.opt;
              cnt_nxt = adv.cnt;
            end
          end
          POS_EXLO: begin
            exlo_nxt = word;
            pos_nxt  = POS_EXHI;
          end
          POS_EXHI: begin
            pos_nxt = adv.pos;
            opt_nxt = adv.opt;
            cnt_nxt = adv.cnt;
          end
          POS_TRACE: begin
            left_nxt = left_dec;
            pos_nxt  = adv.pos;
            opt_nxt  = adv.opt;
            cnt_nxt  = adv.cnt;
          end
          default: pos_nxt = POS_IDLE;
        endcase
      end
    end
  end

  // Result record for the current word
  always_comb begin
    push.valid          = 1'b0;
    push.res.kind       = KIND_HEADER;
    push.res.value      = 48'd0;
    push.res.channel    = ident_r[3:0];
    push.res.slot       = ident_r[7:4];
    push.res.crate      = ident_r[11:8];
    push.res.header_len = hl;
    push.res.event_len  = el;
    push.res.flags      = {adv.last, ident_r[31], ident_r[30]};
    push.res.fine_time  = fine_r;
    push.res.energy     = energy_r;
    push.res.trace_len  = tlen_r;
    if (acc && !start_req) begin
      unique case (pos_r)
        POS_FOURTH: begin
          push.valid         = 1'b1;
          push.res.energy    = word[15:0];
          push.res.trace_len = tl;
          if (!smap.ok) begin
            push.res.kind  = KIND_BAD_HLEN;
            push.res.flags = {1'b1, ident_r[31], ident_r[30]};
          end else if (mismatch) begin
            push.res.kind  = KIND_MISMATCH;
            push.res.flags = {1'b1, ident_r[31], ident_r[30]};
          end
        end
        POS_ESUM, POS_QDC: begin
          push.valid     = 1'b1;
          push.res.kind  = (pos_r == POS_ESUM) ? KIND_ESUM : KIND_QDC;
          push.res.value = {16'd0, word};
          push.res.flags = {(cnt_dec == 4'd0) && adv.last, ident_r[31], ident_r[30]};
        end
        POS_EXHI: begin
          push.valid     = 1'b1;
          push.res.kind  = KIND_EXCLK;
          push.res.value = {word[15:0], exlo_r};
        end
        POS_TRACE: begin
          push.valid     = 1'b1;
          push.res.kind  = KIND_TRACE;
          push.res.value = {16'd0, word};
        end
        default: push.valid = 1'b0;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      opt_r  <= 3'b000;
      cnt_r  <= 4'd0;
      left_r <= 13'd0;
    end else begin
      pos_r  <= pos_nxt;
      opt_r  <= opt_nxt;
      cnt_r  <= cnt_nxt;
      left_r <= left_nxt;
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    ident_r  <= ident_nxt;
    tslow_r  <= tslow_nxt;
    fine_r   <= fine_nxt;
    exlo_r   <= exlo_nxt;
    energy_r <= energy_nxt;
    tlen_r   <= tlen_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/dcu_queue.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module dcu_queue
  import dcu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire dcu_push_t push,
  output logic       full,
  output logic       not_empty,
  input  wire logic  pop,
  output dcu_result_t head
);

  dcu_result_t          mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_r, wr_nxt;
  logic [QUEUE_AW-1:0]  rd_r, rd_nxt;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;
  logic                 do_pop;

  assign full      = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_r];

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = push.valid ? wr_r + QUEUE_AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QUEUE_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (QUEUE_AW+1)'(push.valid) - (QUEUE_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store a pushed record
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_r] <= push.res;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/dcu_back.sv
// Output stage: takes records from the queue and holds them until transferred.
`timescale 1ns / 1ps
`default_nettype none
module dcu_back
  import dcu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  not_empty,
  input  wire dcu_result_t           head,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [KIND_W-1:0]          out_tuser
);

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;

  // Load a new record whenever the register is empty or being drained
  assign pop = not_empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    if (pop) begin
      valid_nxt = 1'b1;
      kind_nxt  = head.kind;
      data_nxt  = {head.value, head.trace_len, head.energy, head.fine_time, head.flags,
                   head.event_len, head.header_len, head.crate, head.slot, head.channel};
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kind_r <= kind_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule
`default_nettype wire

>>> hw/rtl/digitizer_channel_event_unpacker_core.sv
// Top level of the digitizer channel event unpacker.
//
// Input stream: one 32-bit event word per transfer on in_tdata; in_tuser
// high marks the event size word that opens an event. Words outside an
// event, and the size and module words, produce no result.
// Output stream: at most one result per input word, the kind on out_tuser
// and all other result fields packed on out_tdata. Every result repeats the
// header fields of its event; flags bit 2 marks the last result of an event.
// Throughput: one word per cycle, sustained, as long as results are taken.
// Each result is registered into the queue and then into the output register
// before it is presented on the output.
// The parser and the output register are parted by a four-entry queue:
// in_tready drops only when that queue is full, so a stalled receiver
// backs up into the input after five pending results (four queued, one
// held in the output register).
// Reset (rst_n low, synchronous) empties the queue and the output register
// and puts the parser in the drop state until the next start word.
`timescale 1ns / 1ps
`default_nettype none
module digitizer_channel_event_unpacker_core
  import dcu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [WORD_W-1:0]     in_tdata,   // word[31:0]
  input  wire logic                  in_tuser,   // start_req
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // channel[3:0] slot[7:4] crate[11:8] header_len[16:12] event_len[29:17]
  // flags[32:30] fine_time[96:33] energy[112:97] trace_len[127:113] value[175:128]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [KIND_W-1:0]          out_tuser   // kind
);

  logic        acc;
  dcu_push_t   push;
  logic        full;
  logic        not_empty;
  logic        pop;
  dcu_result_t head;

  assign in_tready = !full;
  assign acc       = in_tvalid && !full;

  dcu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .word      (in_tdata),
    .start_req (in_tuser),
    .push      (push)
  );

  dcu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .head      (head)
  );

  dcu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the digitizer channel event unpacker core.
module tb;
  import dcu_pkg::*;

  localparam int PHASE_ITEMS = 200;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  localparam logic [2:0] NO_FLAGS  = 3'b000;
  localparam logic [2:0] FLAG_OVF  = 3'b001;
  localparam logic [2:0] FLAG_FIN  = 3'b010;
  localparam logic [2:0] FLAG_LAST = 3'b100;

  // Shapes of the random events
  typedef enum int {EV_GOOD, EV_BAD_HLEN, EV_MISMATCH, EV_CUT, EV_NOISE} ev_shape_t;

  // One directed word; lit marks a row whose kind and flags are given here
  typedef struct packed {
    logic [31:0]       word;
    logic              start;
    logic              lit;
    logic [KIND_W-1:0] kind;
    logic [2:0]        flags;
  } dir_row_t;

  localparam int DIR_N = 31;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // idle word after reset, dropped
    '{32'hFFFF_FFFF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    // header only, event length equals header length, lowest fine time
    '{32'h0000_0006, 1'b1, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h4008_4F0F, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0000_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h4000_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, KIND_HEADER, FLAG_OVF | FLAG_LAST},
    // event cut short by a fresh start
    '{32'h1234_5678, 1'b1, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0000_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    // bad header length, highest fine time, ignored top bits set
    '{32'h0000_0000, 1'b1, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hBFFF_F0F0, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hBFFF_FFFF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0000_0000, 1'b0, 1'b1, KIND_BAD_HLEN, FLAG_FIN | FLAG_LAST},
    // length mismatch
    '{32'h0000_000A, 1'b1, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0000_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0012_6321, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h89AB_CDEF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h7FFF_1234, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0001_1111, 1'b0, 1'b1, KIND_MISMATCH, FLAG_LAST},
    // external clock and one trace pair, then a dropped word
    '{32'h0000_000B, 1'b1, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h5555_5555, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h000E_6A5C, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0000_0001, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0001_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'h0003_8000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_CAFE, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hFFFF_0000, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata   = '0;   // word[31:0]
  logic                  in_tuser   = 1'b0; // start_req
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // channel[3:0] slot[7:4] crate[11:8] header_len[16:12] event_len[29:17]
  // flags[32:30] fine_time[96:33] energy[112:97] trace_len[127:113] value[175:128]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;  // kind

  // Shadow of the word on the input, carrying the literal expectation
  logic                  lit_on    = 1'b0;
  logic [KIND_W-1:0]     lit_kind  = KIND_HEADER;
  logic [2:0]            lit_flags = NO_FLAGS;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int err_cnt      = 0;
  int n_in         = 0;
  int n_out        = 0;
  int kinds_seen [8];

  dcu_result_t pending_results [$];

  // Parser state
  pos_t        at_pos;
  logic        dropping;
  logic [31:0] id_word;
  logic [31:0] ts_lo;
  logic [31:0] fourth_w;
  logic [31:0] exclk_lo;
  logic [63:0] ftime;
  logic [3:0]  sec_left;
  logic [2:0]  opt_left;
  logic [12:0] trace_left;

  digitizer_channel_event_unpacker_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map a header length to {valid, ext clock, qdc, energy sums}
  function automatic logic [3:0] hlen_sections(input logic [4:0] hl);
    case (hl)
      5'd4:    return 4'b1000;
      5'd6:    return 4'b1100;
      5'd8:    return 4'b1001;
      5'd10:   return 4'b1101;
      5'd12:   return 4'b1010;
      5'd14:   return 4'b1110;
      5'd16:   return 4'b1011;
      default: return 4'b0000;
    endcase
  endfunction

  // Build a result from the event header held so far
  function automatic dcu_result_t make_result(input logic [KIND_W-1:0] k, input logic [47:0] v,
                                              input logic last);
    dcu_result_t r;
    r.kind       = k;
    r.channel    = id_word[3:0];
    r.slot       = id_word[7:4];
    r.crate      = id_word[11:8];
    r.header_len = id_word[16:12];
    r.event_len  = id_word[29:17];
    r.flags      = {last, id_word[31], id_word[30]};
    r.fine_time  = ftime;
    r.energy     = fourth_w[15:0];
    r.trace_len  = fourth_w[30:16];
    r.value      = v;
    return r;
  endfunction

  function automatic string show(input dcu_result_t r);
    return $sformatf("kind=%0d ch=%0d slot=%0d crate=%0d hl=%0d el=%0d flags=%b ft=%0d e=%h tl=%0d v=%h",
                     r.kind, r.channel, r.slot, r.crate, r.header_len, r.event_len, r.flags,
                     $signed(r.fine_time), r.energy, r.trace_len, r.value);
  endfunction

  task automatic reset_parser();
    at_pos     = POS_IDLE;
    dropping   = 1'b1;
    id_word    = '0;
    ts_lo      = '0;
    fourth_w   = '0;
    exclk_lo   = '0;
    ftime      = '0;
    sec_left   = '0;
    opt_left   = '0;
    trace_left = '0;
  endtask

  // Move on to the next optional section, the trace, or close the event
  task automatic open_next_section(output logic done);
    done = 1'b0;
    if (opt_left[OPT_ESUM_BIT]) begin
      opt_left[OPT_ESUM_BIT] = 1'b0;
      sec_left = ESUM_WORDS;
      at_pos   = POS_ESUM;
    end else if (opt_left[OPT_QDC_BIT]) begin
      opt_left[OPT_QDC_BIT] = 1'b0;
      sec_left = QDC_WORDS;
      at_pos   = POS_QDC;
    end else if (opt_left[OPT_EXCLK_BIT]) begin
      opt_left[OPT_EXCLK_BIT] = 1'b0;
      at_pos = POS_EXLO;
    end else if (trace_left != 13'd0) begin
      at_pos = POS_TRACE;
    end else begin
      at_pos   = POS_IDLE;
      dropping = 1'b1;
      done     = 1'b1;
    end
  endtask

  // Advance the parser by one accepted word; hit tells whether a result is due
  task automatic parse_word(input logic [31:0] w, input logic start, output logic hit,
                            output dcu_result_t r);
    logic [3:0]        sec;
    logic [4:0]        hl;
    logic [12:0]       el;
    logic [14:0]       tl;
    logic [47:0]       ts48;
    logic              done;
    logic [KIND_W-1:0] k;
    hit  = 1'b0;
    r    = '0;
    done = 1'b0;
    if (start) begin
      dropping   = 1'b0;
      at_pos     = POS_MODULE;
      opt_left   = '0;
      sec_left   = '0;
      trace_left = '0;
    end else if (!dropping) begin
      case (at_pos)
        POS_MODULE: begin
          at_pos = POS_IDENT;
        end
        POS_IDENT: begin
          id_word = w;
          at_pos  = POS_TSLOW;
        end
        POS_TSLOW: begin
          ts_lo  = w;
          at_pos = POS_TSHIGH;
        end
        POS_TSHIGH: begin
          ts48   = {w[15:0], ts_lo};
          ftime  = ({15'd0, ts48, 1'b0} - 64'(w[30])) * 64'd16384 + 64'(w[29:16]);
          at_pos = POS_FOURTH;
        end
        POS_FOURTH: begin
          fourth_w = w;
          hl  = id_word[16:12];
          el  = id_word[29:17];
          tl  = w[30:16];
          sec = hlen_sections(hl);
          hit = 1'b1;
          if (!sec[3]) begin
            r        = make_result(KIND_BAD_HLEN, 48'd0, 1'b1);
            dropping = 1'b1;
            at_pos   = POS_IDLE;
          end else if (int'(el) != int'(hl) && int'(el) != int'(hl) + int'(tl) / 2) begin
            r        = make_result(KIND_MISMATCH, 48'd0, 1'b1);
            dropping = 1'b1;
            at_pos   = POS_IDLE;
          end else begin
            opt_left   = sec[2:0];
            trace_left = (int'(el) != int'(hl)) ? 13'(tl / 2) : 13'd0;
            open_next_section(done);
            r = make_result(KIND_HEADER, 48'd0, done);
          end
        end
        POS_ESUM, POS_QDC: begin
          k = (at_pos == POS_ESUM) ? KIND_ESUM : KIND_QDC;
          sec_left = sec_left - 4'd1;
          if (sec_left == 4'd0) open_next_section(done);
          r   = make_result(k, {16'd0, w}, done);
          hit = 1'b1;
        end
        POS_EXLO: begin
          exclk_lo = w;
          at_pos   = POS_EXHI;
        end
        POS_EXHI: begin
          open_next_section(done);
          r   = make_result(KIND_EXCLK, {w[15:0], exclk_lo}, done);
          hit = 1'b1;
        end
        POS_TRACE: begin
          trace_left = trace_left - 13'd1;
          open_next_section(done);
          r   = make_result(KIND_TRACE, {16'd0, w}, done);
          hit = 1'b1;
        end
        default: begin
          dropping = 1'b1;
          at_pos   = POS_IDLE;
        end
      endcase
    end
  endtask

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
  endtask

  // Append a predicted result to the tail of the scoreboard
  function automatic void add_pending(input dcu_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Stall the receiver at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check each result transfer, then predict from each word transfer
  always @(posedge clk) begin
    dcu_result_t got;
    dcu_result_t want;
    logic        hit;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata};
        n_out++;
        if (pending_results.size() == 0) begin
          flag_error($sformatf("result with none expected: %s", show(got)));
        end else begin
          want = pending_results.pop_front();
          kinds_seen[want.kind]++;
          if (got !== want)
            flag_error($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                 show(want), show(got)));
        end
      end
      if (in_tvalid && in_tready) begin
        n_in++;
        parse_word(in_tdata, in_tuser, hit, want);
        if (lit_on) begin
          want.kind  = lit_kind;
          want.flags = lit_flags;
          hit        = 1'b1;
        end
        if (hit) add_pending(want);
      end
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("stalled for %0d cycles with %0d results outstanding", QUIET_LIMIT,
             pending_results.size());
    $display("FAILURE");
    $finish;
  end

  // Offer one word, with a random gap first, and hold it until the transfer
  task automatic send_word(input logic [31:0] w, input logic s, input logic lit,
                           input logic [KIND_W-1:0] k, input logic [2:0] f);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= s;
    lit_on    <= lit;
    lit_kind  <= k;
    lit_flags <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the input until every predicted result has arrived
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Send one random event of the given shape; n_sent counts words that take part
  task automatic send_event(input ev_shape_t shape, output int n_sent);
    logic [32:0] words [$];
    logic [31:0] ident;
    logic [31:0] fourth;
    logic [4:0]  hl;
    logic [12:0] el;
    logic [14:0] tl;
    logic [3:0]  sec;
    int          n_opt;
    int          keep;
    int          pick;
    n_sent = 0;
    if (shape == EV_NOISE) begin
      repeat ($urandom_range(1, 4)) send_word($urandom, 1'b0, 1'b0, KIND_HEADER, NO_FLAGS);
    end else begin
      if (shape == EV_BAD_HLEN) begin
        do begin
          hl  = 5'($urandom);
          sec = hlen_sections(hl);
        end while (sec[3]);
      end else begin
        hl  = 5'(4 + 2 * $urandom_range(0, 6));
        sec = hlen_sections(hl);
      end
      pick = $urandom_range(0, 49);
      if (shape == EV_BAD_HLEN || shape == EV_MISMATCH) begin
        tl = 15'($urandom);
        el = 13'($urandom);
      end else if (pick < 12) begin
        // no trace taken, whatever the trace length says
        tl = 15'($urandom);
        el = 13'(hl);
      end else begin
        tl = 15'((pick == 12) ? $urandom_range(0, 200) : $urandom_range(0, 13));
        el = 13'(int'(hl) + int'(tl) / 2);
      end
      ident = $urandom;
      ident[29:12] = {el, hl};
      fourth = $urandom;
      fourth[30:16] = tl;
      words.insert(words.size(), {1'b1, 32'($urandom)});
      words.insert(words.size(), {1'b0, 32'($urandom)});
      words.insert(words.size(), {1'b0, ident});
      words.insert(words.size(), {1'b0, 32'($urandom)});
      words.insert(words.size(), {1'b0, 32'($urandom)});
      words.insert(words.size(), {1'b0, fourth});
      n_opt = 0;
      if (shape == EV_GOOD || shape == EV_CUT)
        n_opt = (sec[0] ? 4 : 0) + (sec[1] ? 8 : 0) + (sec[2] ? 2 : 0) +
                ((el != 13'(hl)) ? int'(tl) / 2 : 0);
      repeat (n_opt) words.insert(words.size(), {1'b0, 32'($urandom)});
      keep = (shape == EV_CUT) ? $urandom_range(1, words.size() - 1) : words.size();
      for (int i = 0; i < keep; i++)
        send_word(words[i][31:0], words[i][32], 1'b0, KIND_HEADER, NO_FLAGS);
      n_sent = keep;
    end
  endtask

  initial begin
    int        sent;
    int        n;
    int        pick;
    ev_shape_t shape;
    reset_parser();
    foreach (kinds_seen[i]) kinds_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the first idling pattern
    idle_pct  = 15;
    stall_pct = 49;
    for (int i = 0; i < DIR_N; i++)
      send_word(DIR_ROWS[i].word, DIR_ROWS[i].start, DIR_ROWS[i].lit, DIR_ROWS[i].kind,
                DIR_ROWS[i].flags);
    wait_results_done();

    // Random events in three idling patterns, draining after each
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) begin
        idle_pct  = 15;
        stall_pct = 49;
      end else if (ph == 1) begin
        idle_pct  = 49;
        stall_pct = 15;
      end else begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 66)      shape = EV_GOOD;
        else if (pick < 74) shape = EV_BAD_HLEN;
        else if (pick < 82) shape = EV_MISMATCH;
        else if (pick < 91) shape = EV_CUT;
        else                shape = EV_NOISE;
        send_event(shape, n);
        sent += n;
      end
      wait_results_done();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words in, %0d results out, %0d errors", n_in, n_out, err_cnt);
    $display("kinds: header %0d esum %0d qdc %0d exclk %0d trace %0d bad-len %0d mismatch %0d",
             kinds_seen[KIND_HEADER], kinds_seen[KIND_ESUM], kinds_seen[KIND_QDC],
             kinds_seen[KIND_EXCLK], kinds_seen[KIND_TRACE], kinds_seen[KIND_BAD_HLEN],
             kinds_seen[KIND_MISMATCH]);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
